@@ rtl/erle_pkg.sv @@
// Shared types and constants for the escape-byte run-length decoder.
// No dependencies; compile first.
package erle_pkg;

  localparam int unsigned POSITION_BITS_DEFAULT = 24;
  localparam int unsigned LENGTH_BITS           = 24;
  localparam int unsigned QUEUE_DEPTH           = 4;

  localparam logic [7:0] ESC_BYTE = 8'hFF;
  localparam logic [7:0] ESC_ZERO = 8'h00;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_MARKER,
    PHASE_COUNTED
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UNCONSUMED,
    ST_OVERFLOW,
    ST_MISMATCH
  } status_t;

  typedef struct packed {
    logic [7:0]             value;
    logic [7:0]             run_length;
    logic [LENGTH_BITS-1:0] position;
    logic                   eos;
    status_t                status;
  } erle_result_t;

  // Up to two descriptors written into the output queue per byte.
  typedef struct packed {
    logic [1:0]   count;
    erle_result_t e0;
    erle_result_t e1;
  } erle_push_t;

endpackage

@@ rtl/erle_if.sv @@
// Handshake channels of the decoder: compressed input, config write, descriptor output.
// Depends on erle_pkg for field widths.
interface erle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface erle_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [erle_pkg::LENGTH_BITS-1:0] expected_length;
  modport source (output valid, output expected_length, input ready);
  modport sink   (input valid, input expected_length, output ready);
endinterface

interface erle_out_if;
  logic                             valid;
  logic                             ready;
  logic [7:0]                       out_value;
  logic [7:0]                       run_length;
  logic [erle_pkg::LENGTH_BITS-1:0] out_position;
  logic                             end_of_stream;
  logic [1:0]                       status;
  modport source (output valid, output out_value, output run_length, output out_position,
                  output end_of_stream, output status, input ready);
  modport sink   (input valid, input out_value, input run_length, input out_position,
                  input end_of_stream, input status, output ready);
endinterface

@@ rtl/erle_out_queue.sv @@
// Small descriptor queue: takes up to two entries a cycle, hands out one beat a cycle while the sink is ready.
// Depends on erle_pkg and erle_out_if.
module erle_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  erle_pkg::erle_push_t push,
  output logic                 room,
  erle_out_if.source           out_ch
);

  localparam int unsigned DEPTH = erle_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  erle_pkg::erle_result_t entry [DEPTH];
  logic [PTR_W-1:0]       head;
  logic [PTR_W-1:0]       tail;
  logic [CNT_W-1:0]       count;
  logic                   pop;

  assign pop  = out_ch.valid && out_ch.ready;
  assign room = count <= CNT_W'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entry[tail] <= push.e0;
    end
    if (push.count == 2'd2) begin
      entry[PTR_W'(tail + 1'b1)] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= PTR_W'(tail + PTR_W'(push.count));
      head  <= PTR_W'(head + PTR_W'(pop));
      count <= CNT_W'(count + CNT_W'(push.count) - CNT_W'(pop));
    end
  end

  assign out_ch.valid         = count != '0;
  assign out_ch.out_value     = entry[head].value;
  assign out_ch.run_length    = entry[head].run_length;
  assign out_ch.out_position  = entry[head].position;
  assign out_ch.end_of_stream = entry[head].eos;
  assign out_ch.status        = entry[head].status;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count past depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(push.count) <= CNT_W'(CNT_W'(DEPTH) - count))
    else $error("queue written without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> count == CNT_W'($past(count) - 1'b1))
    else $error("queue count not decremented on pop");
`endif

endmodule

@@ rtl/escape_rle_byte_decoder_core.sv @@
// Escape-byte run-length decoder core: one compressed byte in, fill descriptors out.
// Depends on erle_pkg, erle_if (channels) and erle_out_queue.
//
// Takes one compressed byte per cycle and emits (value, length, position)
// descriptors for a downstream writer that does the actual fill. 0xFF 0x00 is
// a literal 0xFF; 0xFF n v (n nonzero) is a run of n copies of v; anything else
// is a literal. Every byte passes through the input register and is decoded
// from there into a four-entry output queue; the sustained rate is one byte per
// clock as long as the output is drained; the only byte that yields two beats
// is a nonzero last byte straight after a marker. The decode state (phase, held
// count, write position, sticky error flags) is registered together with that
// byte's descriptors, so back-to-back bytes see each other's effect with no
// bubble. The last byte of a stream carries the status on its final descriptor
// (or a zero-length status-only beat): 0 ok, 1 input left over after the output
// filled, 2 run overflow, 3 size mismatch. After it the decode state clears for
// the next stream.
// expected_length may only be rewritten while the block is quiet.
module escape_rle_byte_decoder_core #(
  parameter int unsigned POSITION_BITS = erle_pkg::POSITION_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  erle_in_if.sink    in_ch,
  erle_cfg_if.sink   cfg,
  erle_out_if.source out_ch
);

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned LB = erle_pkg::LENGTH_BITS;

  // Config register
  logic [LB-1:0]    expected_length;
  logic [PB+LB-1:0] lim_ext;
  logic [PB-1:0]    lim;

  // Input register
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;

  // Decode state
  erle_pkg::phase_t phase;
  erle_pkg::phase_t phase_next;
  logic [7:0]       held_count;
  logic [7:0]       held_count_next;
  logic [PB-1:0]    wp;
  logic [PB-1:0]    wp_next;
  logic             ovf;
  logic             ovf_next;
  logic             unc;
  logic             unc_next;

  // Decode datapath
  logic                 fire;
  logic                 room;
  logic                 full0;
  logic [PB-1:0]        wp_p1;
  logic [PB-1:0]        wp_p2;
  logic [PB:0]          run_end;
  erle_pkg::status_t    st;
  erle_pkg::erle_push_t push;
  erle_pkg::erle_push_t decoded;

  function automatic logic [LB-1:0] to_pos(input logic [PB-1:0] p);
    logic [PB+LB-1:0] wide;
    wide = {{LB{1'b0}}, p};
    return wide[LB-1:0];
  endfunction

  function automatic erle_pkg::erle_result_t make_desc(input logic [7:0] v,
                                                       input logic [7:0] len,
                                                       input logic [PB-1:0] p);
    erle_pkg::erle_result_t r;
    r.value      = v;
    r.run_length = len;
    r.position   = to_pos(p);
    r.eos        = 1'b0;
    r.status     = erle_pkg::ST_OK;
    return r;
  endfunction

  // Only the low POSITION_BITS of the length act as the limit.
  assign lim_ext = {{PB{1'b0}}, expected_length};
  assign lim     = lim_ext[PB-1:0];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= '0;
    end else if (cfg.valid && cfg.ready) begin
      expected_length <= cfg.expected_length;
    end
  end

  // Input register: refills in the same cycle it is decoded.
  assign fire        = stage_valid && room;
  assign in_ch.ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_byte <= in_ch.in_byte;
      stage_last <= in_ch.last_byte;
    end
  end

  assign full0   = wp >= lim;
  assign wp_p1   = PB'(wp + PB'(1));
  assign wp_p2   = PB'(wp + PB'(2));
  assign run_end = {1'b0, wp} + (PB + 1)'(held_count);

  // Next phase; any last byte closes the stream.
  always_comb begin
    phase_next = erle_pkg::PHASE_IDLE;
    if (!stage_last && !ovf) begin
      case (phase)
        erle_pkg::PHASE_IDLE: begin
          if (!full0 && stage_byte == erle_pkg::ESC_BYTE) begin
            phase_next = erle_pkg::PHASE_MARKER;
          end
        end
        erle_pkg::PHASE_MARKER: begin
          if (stage_byte != erle_pkg::ESC_ZERO) begin
            phase_next = erle_pkg::PHASE_COUNTED;
          end
        end
        default: phase_next = erle_pkg::PHASE_IDLE;
      endcase
    end
  end

  // Descriptors and data state for the byte in the input register.
  always_comb begin
    decoded         = '0;
    wp_next         = wp;
    held_count_next = held_count;
    ovf_next        = ovf;
    unc_next        = unc;
    st              = erle_pkg::ST_OK;

    if (!ovf) begin
      case (phase)
        erle_pkg::PHASE_IDLE: begin
          if (full0) begin
            unc_next = 1'b1;
          end else if (stage_byte != erle_pkg::ESC_BYTE || stage_last) begin
            decoded.e0    = make_desc(stage_byte, 8'd1, wp);
            decoded.count = 2'd1;
            wp_next       = wp_p1;
          end
        end
        erle_pkg::PHASE_MARKER: begin
          if (stage_byte != erle_pkg::ESC_ZERO && !stage_last) begin
            held_count_next = stage_byte;
          end else if (full0) begin
            // limit lowered under a pending marker
            ovf_next = 1'b1;
          end else begin
            decoded.e0    = make_desc(erle_pkg::ESC_BYTE, 8'd1, wp);
            decoded.count = 2'd1;
            wp_next       = wp_p1;
            // marker cut short by a nonzero last byte: that byte follows as a literal
            if (stage_byte != erle_pkg::ESC_ZERO) begin
              if (wp_p1 >= lim) begin
                unc_next = 1'b1;
              end else begin
                decoded.e1    = make_desc(stage_byte, 8'd1, wp_p1);
                decoded.count = 2'd2;
                wp_next       = wp_p2;
              end
            end
          end
        end
        erle_pkg::PHASE_COUNTED: begin
          held_count_next = '0;
          if (run_end > {1'b0, lim}) begin
            ovf_next = 1'b1;
          end else begin
            decoded.e0    = make_desc(stage_byte, held_count, wp);
            decoded.count = 2'd1;
            wp_next       = run_end[PB-1:0];
          end
        end
        default: begin
          held_count_next = '0;
        end
      endcase
    end else begin
      held_count_next = held_count;
    end

    if (stage_last) begin
      if (ovf_next) begin
        st = erle_pkg::ST_OVERFLOW;
      end else if (wp_next != lim) begin
        st = erle_pkg::ST_MISMATCH;
      end else if (unc_next) begin
        st = erle_pkg::ST_UNCONSUMED;
      end else begin
        st = erle_pkg::ST_OK;
      end

      case (decoded.count)
        2'd0: begin
          decoded.e0        = make_desc(8'd0, 8'd0, wp_next);
          decoded.e0.eos    = 1'b1;
          decoded.e0.status = st;
          decoded.count     = 2'd1;
        end
        2'd1: begin
          decoded.e0.eos    = 1'b1;
          decoded.e0.status = st;
        end
        default: begin
          decoded.e1.eos    = 1'b1;
          decoded.e1.status = st;
        end
      endcase

      wp_next         = '0;
      held_count_next = '0;
      ovf_next        = 1'b0;
      unc_next        = 1'b0;
    end
  end

  always_comb begin
    push = decoded;
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= erle_pkg::PHASE_IDLE;
      held_count <= '0;
      wp         <= '0;
      ovf        <= 1'b0;
      unc        <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      held_count <= held_count_next;
      wp         <= wp_next;
      ovf        <= ovf_next;
      unc        <= unc_next;
    end
  end

  erle_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  a_pair_only_at_end: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> stage_last)
    else $error("two descriptors from a byte that is not last");

  a_stream_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && stage_last) |=> (wp == '0 && !ovf && !unc && phase == erle_pkg::PHASE_IDLE))
    else $error("decode state not cleared after stream end");

  a_no_beat_after_overflow: assert property (@(posedge clk) disable iff (rst)
    (fire && ovf && !stage_last) |-> push.count == 2'd0)
    else $error("descriptor issued after run overflow");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for escape_rle_byte_decoder_core: fill descriptors checked against a
// cycle-free decode predictor. Depends on erle_pkg, erle_if and the core itself.

// Predicts the descriptor beats of the decoder and checks them in order.
class fill_scoreboard;
  erle_pkg::erle_result_t           pending_fills[$];
  erle_pkg::phase_t                 phase;
  logic [7:0]                       held_count;
  logic [erle_pkg::LENGTH_BITS-1:0] write_pos;
  logic [erle_pkg::LENGTH_BITS-1:0] fill_limit;
  bit                               overflow_seen;
  bit                               input_left;
  int                               step_beats;
  int                               errors;
  int                               beats_checked;
  int                               streams_closed;
  int                               status_tally[4];

  function new();
    fill_limit = '0;
    errors = 0;
    beats_checked = 0;
    streams_closed = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    clear_stream();
  endfunction

  function void clear_stream();
    phase = erle_pkg::PHASE_IDLE;
    held_count = '0;
    write_pos = '0;
    overflow_seen = 1'b0;
    input_left = 1'b0;
  endfunction

  function void set_limit(logic [erle_pkg::LENGTH_BITS-1:0] v);
    fill_limit = v;
  endfunction

  function erle_pkg::erle_result_t make_fill(logic [7:0] v, logic [7:0] len,
                                             logic [erle_pkg::LENGTH_BITS-1:0] pos);
    erle_pkg::erle_result_t r;
    r.value = v;
    r.run_length = len;
    r.position = pos;
    r.eos = 1'b0;
    r.status = erle_pkg::ST_OK;
    return r;
  endfunction

  function void add_literal(logic [7:0] v);
    if (write_pos >= fill_limit) begin
      overflow_seen = 1'b1;
      return;
    end
    pending_fills.push_back(make_fill(v, 8'd1, write_pos));
    step_beats++;
    write_pos = write_pos + 1'b1;
  endfunction

  // Runs one compressed byte through the decode; returns 0 when the byte is ignored.
  function bit accept_byte(logic [7:0] b, logic is_last);
    bit                             used;
    logic [erle_pkg::LENGTH_BITS:0] run_end;
    erle_pkg::status_t              st;
    erle_pkg::erle_result_t         tail;
    used = 1'b1;
    step_beats = 0;
    if (overflow_seen) begin
      phase = erle_pkg::PHASE_IDLE;
      used = 1'b0;
    end else if (phase == erle_pkg::PHASE_IDLE) begin
      if (write_pos >= fill_limit) begin
        input_left = 1'b1;
        used = 1'b0;
      end else if (b == erle_pkg::ESC_BYTE && !is_last) begin
        phase = erle_pkg::PHASE_MARKER;
      end else begin
        add_literal(b);
      end
    end else if (phase == erle_pkg::PHASE_MARKER) begin
      phase = erle_pkg::PHASE_IDLE;
      if (b == erle_pkg::ESC_ZERO) begin
        add_literal(erle_pkg::ESC_BYTE);
      end else if (!is_last) begin
        held_count = b;
        phase = erle_pkg::PHASE_COUNTED;
      end else begin
        add_literal(erle_pkg::ESC_BYTE);
        if (!overflow_seen) begin
          if (write_pos >= fill_limit) input_left = 1'b1;
          else add_literal(b);
        end
      end
    end else begin
      phase = erle_pkg::PHASE_IDLE;
      run_end = {1'b0, write_pos} + (erle_pkg::LENGTH_BITS + 1)'(held_count);
      if (run_end > {1'b0, fill_limit}) begin
        overflow_seen = 1'b1;
      end else begin
        pending_fills.push_back(make_fill(b, held_count, write_pos));
        step_beats++;
        write_pos = run_end[erle_pkg::LENGTH_BITS-1:0];
      end
      held_count = '0;
    end

    if (is_last) begin
      if (overflow_seen) st = erle_pkg::ST_OVERFLOW;
      else if (write_pos != fill_limit) st = erle_pkg::ST_MISMATCH;
      else if (input_left) st = erle_pkg::ST_UNCONSUMED;
      else st = erle_pkg::ST_OK;
      if (step_beats > 0) begin
        tail = pending_fills.pop_back();
      end else begin
        tail = make_fill(8'd0, 8'd0, write_pos);
      end
      tail.eos = 1'b1;
      tail.status = st;
      pending_fills.push_back(tail);
      status_tally[st]++;
      streams_closed++;
      clear_stream();
    end
    return used;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] ERROR %s", $time, msg);
  endfunction

  function void check_fill(erle_pkg::erle_result_t got);
    erle_pkg::erle_result_t want;
    beats_checked++;
    if (pending_fills.size() == 0) begin
      flag($sformatf("unexpected beat val=%02h len=%0d pos=%0d eos=%0b st=%0d",
                     got.value, got.run_length, got.position, got.eos, got.status));
      return;
    end
    want = pending_fills.pop_front();
    if (got.value != want.value || got.run_length != want.run_length ||
        got.position != want.position || got.eos != want.eos ||
        got.status != want.status)
      flag($sformatf({"beat mismatch: exp val=%02h len=%0d pos=%0d eos=%0b st=%0d,",
                      " got val=%02h len=%0d pos=%0d eos=%0b st=%0d"},
                     want.value, want.run_length, want.position, want.eos, want.status,
                     got.value, got.run_length, got.position, got.eos, got.status));
  endfunction

  function void report_leftover();
    if (pending_fills.size() != 0)
      flag($sformatf("%0d expected beats never arrived", pending_fills.size()));
  endfunction
endclass

module tb;

  localparam int ITEM_TARGET   = 1850;    // compressed bytes to send in all
  localparam int SETTLE_CYCLES = 8;       // input register and queue drain plus margin
  localparam int CYCLE_LIMIT   = 600000;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic clk;
  logic rst;

  erle_in_if  in_ch();
  erle_cfg_if cfg();
  erle_out_if out_ch();

  escape_rle_byte_decoder_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .out_ch (out_ch)
  );

  fill_scoreboard sb;

  int          cycles;
  int          decoded_bytes;
  int          sent_bytes;
  int          streams_sent;
  int          burst_left;
  int          cur_limit;
  logic [8:0]  stream_q[$];   // {last, byte}

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: a correct run finishes far inside this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles,
               sb.pending_fills.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Handshake monitor. Every input beat feeds the predictor, every output beat is
  // checked. A descriptor never leaves in the cycle its byte goes in, so order here
  // within one edge does not matter.
  always @(posedge clk) begin : monitor
    erle_pkg::erle_result_t got;
    if (!rst) begin
      if (cfg.valid && cfg.ready) sb.set_limit(cfg.expected_length);
      if (in_ch.valid && in_ch.ready) begin
        sent_bytes++;
        if (sb.accept_byte(in_ch.in_byte, in_ch.last_byte)) decoded_bytes++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.value      = out_ch.out_value;
        got.run_length = out_ch.run_length;
        got.position   = out_ch.out_position;
        got.eos        = out_ch.end_of_stream;
        got.status     = erle_pkg::status_t'(out_ch.status);
        sb.check_fill(got);
      end
    end
  end

  // Descriptor sink: back-pressure switches between a few patterns, one of them
  // never stalling, so stalls land on every phase of the decode.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       stall_left;
    out_ch.ready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12);
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // One compressed byte. The sender runs in bursts; between bursts valid drops for
  // a random gap. Valid is left high on return so back-to-back beats keep it up.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.last_byte <= is_last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending, let every owed beat drain, then give the pipe time to empty.
  // One edge first so the monitor has logged the byte accepted at the last edge.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_fills.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    cfg.valid           <= 1'b1;
    cfg.expected_length <= v[erle_pkg::LENGTH_BITS-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cur_limit = v;
  endtask

  function automatic int pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 12) return 24'hFFFFFF;
    if (r < 20) return $urandom_range(0, 24'hFFFFFF);
    if (r < 60) return $urandom_range(1, 40);
    return $urandom_range(41, 3000);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    stream_q.push_back({1'b0, b});
  endfunction

  // Mostly well-formed streams aimed at the limit, then a chosen ending: exact fit,
  // trailing bytes after full, a run too long, a marker as the last byte, a marker
  // cut short by the last byte, or a stream stopped short.
  function automatic void build_stream(int lim);
    int left;
    int tokens;
    int n;
    int kind;
    int ending;
    int extra;
    stream_q.delete();
    left = lim;
    tokens = 0;
    ending = $urandom_range(0, 99);
    if (ending < 10) left = $urandom_range(0, lim);
    while (left > 0 && tokens < 48) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        push_byte(8'($urandom_range(0, 254)));
        left--;
      end else if (kind < 7) begin
        push_byte(erle_pkg::ESC_BYTE);
        push_byte(erle_pkg::ESC_ZERO);
        left--;
      end else begin
        n = $urandom_range(1, (left < 255) ? left : 255);
        push_byte(erle_pkg::ESC_BYTE);
        push_byte(8'(n));
        push_byte(8'($urandom_range(0, 255)));
        left -= n;
      end
      tokens++;
    end
    if (ending >= 60 && ending < 75) begin
      extra = $urandom_range(1, 4);
      repeat (extra) push_byte(8'($urandom_range(0, 255)));
    end else if (ending >= 75 && ending < 85) begin
      push_byte(erle_pkg::ESC_BYTE);
      push_byte(8'($urandom_range(1, 255)));
      push_byte(8'($urandom_range(0, 255)));
      extra = $urandom_range(0, 3);
      repeat (extra) push_byte(8'($urandom_range(0, 255)));
    end else if (ending >= 85 && ending < 93) begin
      push_byte(erle_pkg::ESC_BYTE);
    end else if (ending >= 93) begin
      push_byte(erle_pkg::ESC_BYTE);
      push_byte(8'($urandom_range(1, 255)));
    end
    if (stream_q.size() == 0) push_byte(8'($urandom_range(0, 255)));
    stream_q[stream_q.size() - 1][8] = 1'b1;
  endfunction

  initial begin
    sb = new();
    decoded_bytes = 0;
    sent_bytes = 0;
    streams_sent = 0;
    burst_left = 0;
    cur_limit = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.last_byte = 1'b0;
    cfg.valid = 1'b0;
    cfg.expected_length = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // Reset limit is zero: a lone byte is ignored, status-only beat, unconsumed.
    send_byte(8'h00, 1'b1);

    // Exact fit: literals, escaped 0xFF and a short run.
    quiesce();
    write_limit(5);
    send_byte(8'h00, 1'b0);
    send_byte(erle_pkg::ESC_BYTE, 1'b0);
    send_byte(erle_pkg::ESC_ZERO, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(erle_pkg::ESC_BYTE, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hAB, 1'b1);

    // Marker as last byte, then marker plus nonzero last byte (two beats); short.
    quiesce();
    write_limit(3);
    send_byte(erle_pkg::ESC_BYTE, 1'b1);
    send_byte(erle_pkg::ESC_BYTE, 1'b0);
    send_byte(8'h80, 1'b1);

    // Run past the limit: error, rest of stream dropped.
    quiesce();
    write_limit(2);
    send_byte(erle_pkg::ESC_BYTE, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);

    // Output full, trailing byte left over.
    quiesce();
    write_limit(1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);

    // Limit lowered under the position while a marker waits.
    quiesce();
    write_limit(4);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(erle_pkg::ESC_BYTE, 1'b0);
    quiesce();
    write_limit(1);
    send_byte(erle_pkg::ESC_ZERO, 1'b1);

    // Largest limit, longest run of 0xFF.
    quiesce();
    write_limit(24'hFFFFFF);
    send_byte(erle_pkg::ESC_BYTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // --- random part ---
    // Most streams start from a fresh limit after a full drain; the rest run
    // straight on from the previous stream with the same limit.
    while (sent_bytes < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 6) begin
        quiesce();
        write_limit(pick_limit());
      end
      build_stream(cur_limit);
      foreach (stream_q[i]) send_byte(stream_q[i][7:0], stream_q[i][8]);
      streams_sent++;
    end

    quiesce();
    sb.report_leftover();
    $display("run: %0d random streams, %0d bytes in (%0d decoded), %0d beats checked",
             streams_sent, sent_bytes, decoded_bytes, sb.beats_checked);
    $display("stream ends: ok %0d, left over %0d, overflow %0d, short %0d; mismatches %0d",
             sb.status_tally[erle_pkg::ST_OK], sb.status_tally[erle_pkg::ST_UNCONSUMED],
             sb.status_tally[erle_pkg::ST_OVERFLOW], sb.status_tally[erle_pkg::ST_MISMATCH],
             sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/erle_pkg.sv
rtl/erle_if.sv
rtl/erle_out_queue.sv
rtl/escape_rle_byte_decoder_core.sv
tb/sv/tb.sv
